>>> hw/rtl/spq_pkg.sv
package spq_pkg;

    // Default queue depth
    localparam int DEPTH_DEF = 64;

    // Field widths
    localparam int PRIO_W   = 16;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Priority reported by a remove on an empty queue
    localparam logic signed [PRIO_W-1:0] PRIO_EMPTY = -16'sd1;

    // Input mode codes
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // One stored entry
    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [VAL_W-1:0]  value;
    } spq_entry_t;

    // Command broadcast to every cell
    typedef struct packed {
        logic       ins;
        logic       rem;
        spq_entry_t item;
    } spq_cmd_t;

endpackage

>>> hw/rtl/sorted_priority_queue.sv
// The result for each accepted item is registered onto m_tdata.
// Throughput: one item per cycle; every cell compares its priority with the
// new item in parallel and shifts by one place, so no item waits on another.
// s_tready drops only while a result waits on a stalled m_tready.
// Reset (aresetn low, synchronous) empties the queue and clears m_tvalid;
// cell contents are not cleared, entries past the count are never read.
module sorted_priority_queue #(
    parameter  int DEPTH      = spq_pkg::DEPTH_DEF,
    localparam int OCC_W      = $clog2(DEPTH + 1),
    localparam int S_TDATA_W  = ((1 + spq_pkg::PRIO_W + spq_pkg::VAL_W + 7) / 8) * 8,
    localparam int M_RAW_W    = spq_pkg::STATUS_W + spq_pkg::PRIO_W + spq_pkg::VAL_W + OCC_W,
    localparam int M_TDATA_W  = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // mode, priority_req, value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status, out_priority, out_value, occupancy
);

    localparam int PW = spq_pkg::PRIO_W;
    localparam int VW = spq_pkg::VAL_W;
    localparam int SW = spq_pkg::STATUS_W;

    // Input unpacking
    logic                 in_mode;
    spq_pkg::spq_entry_t  in_item;
    assign in_mode       = s_tdata[0];
    assign in_item.prio  = s_tdata[PW:1];
    assign in_item.value = s_tdata[PW+VW:PW+1];

    logic [OCC_W-1:0] count_reg;
    logic [OCC_W-1:0] count_next;
    logic             out_valid_reg;
    logic [SW-1:0]    status_reg;
    logic [SW-1:0]    status_next;
    logic signed [PW-1:0] oprio_reg;
    logic signed [PW-1:0] oprio_next;
    logic signed [VW-1:0] oval_reg;
    logic signed [VW-1:0] oval_next;
    logic [OCC_W-1:0] occ_reg;

    logic accept;
    logic is_full;
    logic is_empty;
    spq_pkg::spq_cmd_t cmd;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign is_full  = (count_reg == OCC_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign cmd.ins  = accept && (in_mode == spq_pkg::MODE_INSERT) && !is_full;
    assign cmd.rem  = accept && (in_mode == spq_pkg::MODE_REMOVE) && !is_empty;
    assign cmd.item = in_item;

    // Chain of cells
    spq_pkg::spq_entry_t cell_entry [DEPTH];
    logic                cell_lt    [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                valid_c;
        logic                left_lt_c;
        spq_pkg::spq_entry_t left_c;
        spq_pkg::spq_entry_t right_c;

        assign valid_c = (OCC_W'(i) < count_reg);

        if (i == 0) begin : g_head
            assign left_lt_c = 1'b0;
            assign left_c    = cmd.item;
        end else begin : g_mid
            assign left_lt_c = cell_lt[i-1];
            assign left_c    = cell_entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign right_c = cell_entry[i];
        end else begin : g_body
            assign right_c = cell_entry[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .cmd         (cmd),
            .valid       (valid_c),
            .left_lt     (left_lt_c),
            .left_entry  (left_c),
            .right_entry (right_c),
            .lt          (cell_lt[i]),
            .entry       (cell_entry[i])
        );
    end

    // Entry count
    always_comb begin
        count_next = count_reg;
        if (cmd.ins) begin
            count_next = count_reg + OCC_W'(1);
        end else if (cmd.rem) begin
            count_next = count_reg - OCC_W'(1);
        end
    end

    // Result
    always_comb begin
        status_next = spq_pkg::ST_INSERTED;
        oprio_next  = '0;
        oval_next   = '0;
        if (in_mode == spq_pkg::MODE_REMOVE) begin
            if (is_empty) begin
                status_next = spq_pkg::ST_EMPTY;
                oprio_next  = spq_pkg::PRIO_EMPTY;
            end else begin
                status_next = spq_pkg::ST_REMOVED;
                oprio_next  = cell_entry[0].prio;
                oval_next   = cell_entry[0].value;
            end
        end else if (is_full) begin
            status_next = spq_pkg::ST_FULL;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg <= status_next;
            oprio_reg  <= oprio_next;
            oval_reg   <= oval_next;
            occ_reg    <= count_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({occ_reg, oval_reg, oprio_reg, status_reg});

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= OCC_W'(DEPTH))
        else $error("entry count above depth");

    a_remove_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rem |=> count_reg == $past(count_reg) - OCC_W'(1))
        else $error("remove did not decrement count");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_mode == spq_pkg::MODE_INSERT && is_full)
        |=> (count_reg == $past(count_reg)) && (status_reg == spq_pkg::ST_FULL))
        else $error("insert on full not dropped");

    a_head_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= OCC_W'(2)) |-> (cell_entry[0].prio >= cell_entry[1].prio))
        else $error("front cells out of order");

endmodule

>>> hw/rtl/spq_cell.sv
module spq_cell (
    input  logic               aclk,
    input  spq_pkg::spq_cmd_t  cmd,
    input  logic               valid,       // cell index below entry count
    input  logic               left_lt,     // left neighbor yields to the new item
    input  spq_pkg::spq_entry_t left_entry,
    input  spq_pkg::spq_entry_t right_entry,
    output logic               lt,          // this cell yields to the new item
    output spq_pkg::spq_entry_t entry
);

    spq_pkg::spq_entry_t entry_reg;
    spq_pkg::spq_entry_t entry_next;

    // Empty cells and strictly lower priorities move back on insert
    assign lt = !valid || (entry_reg.prio < cmd.item.prio);

    // Insert: take left neighbor if it also moves, else the new item.
    // Remove: take right neighbor.
    always_comb begin
        entry_next = entry_reg;
        if (cmd.ins && lt) begin
            entry_next = left_lt ? left_entry : cmd.item;
        end else if (cmd.rem) begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule
